// ----- design/sorted_descending_list_top_assert.svh -----
// Assertion macros for the checker file.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef SORTED_DESCENDING_LIST_TOP_ASSERT_SVH
`define SORTED_DESCENDING_LIST_TOP_ASSERT_SVH

// Same-cycle implication.
`define SDL_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sorted list assertion failed");

// Next-cycle implication.
`define SDL_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sorted list assertion failed");

`endif

// ----- design/sdl_pkg.sv -----
`timescale 1ns / 1ps

package sdl_pkg;

	localparam int DATA_W  = 32;
	localparam int OP_W    = 3;
	localparam int POS_W   = 6;
	localparam int COUNT_W = 6;

	localparam logic [OP_W-1:0] OP_INSERT    = 3'd0;
	localparam logic [OP_W-1:0] OP_REMOVE    = 3'd1;
	localparam logic [OP_W-1:0] OP_DROP_NEG  = 3'd2;
	localparam logic [OP_W-1:0] OP_DROP_EVEN = 3'd3;
	localparam logic [OP_W-1:0] OP_READ      = 3'd4;
	localparam logic [OP_W-1:0] OP_CLEAR     = 3'd5;

	typedef logic signed [DATA_W-1:0] entry_t;

	typedef struct packed {
		logic [OP_W-1:0]  operation;
		entry_t           value;
		logic [POS_W-1:0] position;
	} cmd_item_t;

	typedef struct packed {
		logic               ok;
		entry_t             element;
		logic [COUNT_W-1:0] count;
		logic               is_empty;
		logic               is_full;
	} rsp_item_t;

	// What every cell does on the next edge.
	typedef enum logic [1:0] {
		ACT_HOLD,
		ACT_INSERT,
		ACT_REMOVE,
		ACT_COMPACT
	} cell_act_t;

	typedef struct packed {
		cell_act_t act;
		entry_t    value;
		logic      kind_even;
	} cell_cmd_t;

	// Status a cell reports to its right neighbor and to the controller.
	typedef struct packed {
		logic ge;
		logic eq;
		logic sel;
		logic prefix;
	} cell_flags_t;

	typedef enum logic [1:0] {
		ST_IDLE    = 2'b01,
		ST_COMPACT = 2'b10
	} sdl_state_t;

endpackage

// ----- design/sdl_stream_if.sv -----
`timescale 1ns / 1ps

interface sdl_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- design/sorted_descending_list_top.sv -----
`timescale 1ns / 1ps
// Sorted list of signed 32-bit values, kept in descending order.
// cmd channel (valid/ready): operation, value, position. Operations are
// insert, remove value, remove negatives, remove evens, read at a 1-based
// position, and clear. Codes 6 and 7 answer with ok = 0.
// rsp channel (valid/ready): ok, element, count, is_empty, is_full; one
// item for every cmd item, in order.
// Insert, remove value, read and clear answer in the cycle after the cmd
// item is taken; while the receiver keeps up, the block can take one such
// item per cycle. Remove negatives and remove evens sweep the list: the
// cell row drops the first matching entry per cycle, and once no entry
// matches the block issues the result.
// No cmd item is taken during that sweep.
// Reset clears the count and control; entry contents are not cleared and
// are only read below the count.
// When the receiver stalls, the response register holds its item and cmd
// ready falls until the item leaves; a new item may enter in the cycle
// the old one is taken.
module sorted_descending_list_top
	import sdl_pkg::*;
#(
	parameter int DEPTH = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	sdl_stream_if.sink   cmd,
	sdl_stream_if.source rsp
);

	localparam int CNT_W = $clog2(DEPTH + 1);

	sdl_state_t       state_q, state_d;
	logic [CNT_W-1:0] used_q, used_d;
	logic             kind_q, kind_d;
	logic             removed_q, removed_d;
	logic             rsp_valid_q;
	rsp_item_t        rsp_data_q;

	cell_cmd_t   cell_cmd;
	entry_t      entries [DEPTH];
	cell_flags_t flags [DEPTH];
	entry_t      rd_data [DEPTH];

	logic      accept;
	logic      out_free;
	logic      found;
	logic      read_hit;
	logic      any_hit;
	entry_t    rd_all;
	logic      res_load;
	rsp_item_t res;

	// Row of cells; cell g holds entry g and trades data with g-1 and g+1.
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		entry_t left_entry;
		logic   left_ge;
		entry_t right_entry;
		logic   prefix_in;

		if (g == 0) begin : g_first
			assign left_entry = '0;
			assign left_ge    = 1'b1;
			assign prefix_in  = 1'b0;
		end else begin : g_inner
			assign left_entry = entries[g-1];
			assign left_ge    = flags[g-1].ge;
			assign prefix_in  = flags[g-1].prefix;
		end

		if (g == DEPTH - 1) begin : g_last
			assign right_entry = entries[g];
		end else begin : g_more
			assign right_entry = entries[g+1];
		end

		sdl_cell #(
			.IDX   (g),
			.CNT_W (CNT_W)
		) u_cell (
			.clk         (clk),
			.cmd         (cell_cmd),
			.used        (used_q),
			.position    (cmd.data.position),
			.left_entry  (left_entry),
			.left_ge     (left_ge),
			.right_entry (right_entry),
			.prefix_in   (prefix_in),
			.entry_q     (entries[g]),
			.flags       (flags[g]),
			.rd_data     (rd_data[g])
		);
	end

	// Gather cell status: an equal entry exists, a read position matched.
	always_comb begin
		found    = 1'b0;
		read_hit = 1'b0;
		rd_all   = '0;
		for (int i = 0; i < DEPTH; i++) begin
			found    = found | flags[i].eq;
			read_hit = read_hit | flags[i].sel;
			rd_all   = rd_all | rd_data[i];
		end
	end

	// The prefix chain ends in the last cell: any entry matched the drop test.
	assign any_hit = flags[DEPTH-1].prefix;

	assign out_free  = !rsp_valid_q || rsp.ready;
	assign cmd.ready = (state_q == ST_IDLE) && out_free;
	assign accept    = cmd.valid && cmd.ready;

	always_comb begin
		state_d            = state_q;
		used_d             = used_q;
		kind_d             = kind_q;
		removed_d          = removed_q;
		cell_cmd.act       = ACT_HOLD;
		cell_cmd.value     = cmd.data.value;
		cell_cmd.kind_even = (state_q == ST_COMPACT) ? kind_q
			: (cmd.data.operation == OP_DROP_EVEN);
		res_load           = 1'b0;
		res.ok             = 1'b0;
		res.element        = '0;

		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					res_load = 1'b1;
					unique case (cmd.data.operation) inside
						OP_INSERT: begin
							// Full list: refuse and keep everything.
							if (used_q != CNT_W'(DEPTH)) begin
								cell_cmd.act = ACT_INSERT;
								used_d       = used_q + CNT_W'(1);
								res.ok       = 1'b1;
							end
						end
						OP_REMOVE: begin
							// Sorted order puts the first equal entry at the first non-greater cell.
							if (found) begin
								cell_cmd.act = ACT_REMOVE;
								used_d       = used_q - CNT_W'(1);
								res.ok       = 1'b1;
							end
						end
						OP_DROP_NEG, OP_DROP_EVEN: begin
							// Answer comes when the sweep ends.
							res_load  = 1'b0;
							state_d   = ST_COMPACT;
							kind_d    = (cmd.data.operation == OP_DROP_EVEN);
							removed_d = 1'b0;
						end
						OP_READ: begin
							res.ok      = read_hit;
							res.element = rd_all;
						end
						OP_CLEAR: begin
							used_d = '0;
							res.ok = 1'b1;
						end
						default: begin
						end
					endcase
				end
			end
			ST_COMPACT: begin
				if (any_hit) begin
					// Drop the first matching entry; cells to its right advance.
					cell_cmd.act = ACT_COMPACT;
					used_d       = used_q - CNT_W'(1);
					removed_d    = 1'b1;
				end else if (out_free) begin
					res_load = 1'b1;
					res.ok   = removed_q;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		res.count    = COUNT_W'(used_d);
		res.is_empty = (used_d == '0);
		res.is_full  = (used_d == CNT_W'(DEPTH));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			used_q      <= '0;
			kind_q      <= 1'b0;
			removed_q   <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			used_q    <= used_d;
			kind_q    <= kind_d;
			removed_q <= removed_d;
			if (res_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Hold the response payload until a new result replaces it.
	always_ff @(posedge clk) begin
		if (res_load) begin
			rsp_data_q <= res;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_data_q;

endmodule

// ----- design/sdl_cell.sv -----
`timescale 1ns / 1ps

module sdl_cell
	import sdl_pkg::*;
#(
	parameter int IDX   = 0,
	parameter int CNT_W = 6
) (
	input  logic             clk,
	input  cell_cmd_t        cmd,
	input  logic [CNT_W-1:0] used,
	input  logic [POS_W-1:0] position,
	input  entry_t           left_entry,
	input  logic             left_ge,
	input  entry_t           right_entry,
	input  logic             prefix_in,
	output entry_t           entry_q,
	output cell_flags_t      flags,
	output entry_t           rd_data
);

	logic valid;
	logic gt;
	logic hit;

	assign valid = used > CNT_W'(IDX);

	always_comb begin
		flags.ge     = valid && (entry_q >= cmd.value);
		flags.eq     = valid && (entry_q == cmd.value);
		flags.sel    = valid && (32'(position) == 32'(IDX + 1));
		gt           = flags.ge && !flags.eq;
		hit          = valid && (cmd.kind_even ? !entry_q[0] : entry_q[DATA_W-1]);
		flags.prefix = prefix_in || hit;
		rd_data      = flags.sel ? entry_q : '0;
	end

	// Insert shifts right from the first smaller entry; removals pull from the right.
	always_ff @(posedge clk) begin
		unique case (cmd.act)
			ACT_INSERT: begin
				if (!flags.ge) begin
					entry_q <= left_ge ? cmd.value : left_entry;
				end
			end
			ACT_REMOVE: begin
				if (!gt) begin
					entry_q <= right_entry;
				end
			end
			ACT_COMPACT: begin
				if (flags.prefix) begin
					entry_q <= right_entry;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// ----- design/sdl_checker.sv -----
`timescale 1ns / 1ps
`include "sorted_descending_list_top_assert.svh"

module sdl_checker
	import sdl_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      cmd_valid,
	input logic      cmd_ready,
	input cmd_item_t cmd_data,
	input logic      rsp_valid,
	input logic      rsp_ready,
	input rsp_item_t rsp_data
);

	// Stalled response stays put.
	`SDL_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

	// No cmd item taken while the response register is blocked.
	`SDL_ASSERT_IMP(a_no_take_on_stall, rsp_valid && !rsp_ready, !cmd_ready)

	// Single-step operations answer on the next cycle.
	`SDL_ASSERT_NXT(a_quick_rsp, cmd_valid && cmd_ready && cmd_data.operation != OP_DROP_NEG && cmd_data.operation != OP_DROP_EVEN, rsp_valid)

	// Clear always succeeds and leaves nothing behind.
	`SDL_ASSERT_NXT(a_clear_empty, cmd_valid && cmd_ready && cmd_data.operation == OP_CLEAR, rsp_data.ok && rsp_data.is_empty && rsp_data.count == '0)

endmodule

bind sorted_descending_list_top sdl_checker u_sdl_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd.valid),
	.cmd_ready (cmd.ready),
	.cmd_data  (cmd.data),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data)
);

// ----- tb/sorted_descending_list_top_tb.sv -----
`timescale 1ns / 1ps

// Testbench for the sorted descending list.
//
// A driver process offers command items from a backlog queue that the
// stimulus block fills before reset is released. It sends them in bursts
// of random length with random gaps in between. A monitor process sees
// every accepted command and replays it on a private copy of the list.
// It queues the status that the block must answer with. When a response
// item is taken, the monitor compares it field by field with the oldest
// queued status. The receiver switches between stall patterns at random
// intervals. Twice it holds off for a long stretch, so the response register
// fills up and the block stalls the command side.
module sorted_descending_list_top_tb;
	import sdl_pkg::*;

	localparam int LIST_DEPTH = 32;
	localparam int RANDOM_ITEMS = 1600;
	// A sweep may drop every entry; leave room for that plus the response.
	localparam int DRAIN_CYCLES = LIST_DEPTH + 8;
	localparam int LONG_HOLD = 200;

	// Codes the block does not implement; they must answer with ok low.
	localparam logic [OP_W-1:0] OP_UNUSED_6 = 3'd6;
	localparam logic [OP_W-1:0] OP_UNUSED_7 = 3'd7;

	typedef struct {
		cmd_item_t cmd;
		bit        settle; // wait for every outstanding response first
	} list_req_t;

	typedef enum int {
		RX_OPEN,
		RX_COIN,
		RX_SPARSE,
		RX_PATTERN
	} rx_mode_t;

	logic clk = 1'b0;
	logic arst_n;

	sdl_stream_if #(.T(cmd_item_t)) cmd_ch ();
	sdl_stream_if #(.T(rsp_item_t)) rsp_ch ();

	sorted_descending_list_top #(
		.DEPTH(LIST_DEPTH)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd_ch),
		.rsp   (rsp_ch)
	);

	always #2 clk = ~clk;

	// ------------------------------------------------------------------
	// Private copy of the list and the status it predicts
	// ------------------------------------------------------------------
	entry_t    list_vals [LIST_DEPTH];
	int        list_count;
	rsp_item_t expected_status [$];

	list_req_t cmd_backlog [$];

	// Handshake counters, updated with nonblocking writes so that the
	// driver and the receiver read settled values at the edge.
	int n_taken;
	int n_done;
	int mismatch_cnt;

	// Coverage tallies for the closing summary.
	int op_tally [8];
	int ok_tally;
	int peak_fill;
	int full_refusals;
	int holds_done;

	// Close the gap left by the entry at idx and shrink the list.
	function automatic void remove_at(int idx);
		for (int i = idx + 1; i < list_count; i++)
			list_vals[i-1] = list_vals[i];
		list_count--;
	endfunction

	function automatic rsp_item_t apply_to_list(cmd_item_t c);
		rsp_item_t r;
		int        idx;
		logic      ok;
		logic      drop;
		entry_t    elem;

		ok   = 1'b0;
		elem = '0;
		case (c.operation)
			OP_INSERT: begin
				if (list_count < LIST_DEPTH) begin
					// Shift smaller entries right; equal ones stay ahead.
					idx = list_count;
					while (idx > 0 && list_vals[idx-1] < c.value) begin
						list_vals[idx] = list_vals[idx-1];
						idx--;
					end
					list_vals[idx] = c.value;
					list_count++;
					ok = 1'b1;
				end
			end
			OP_REMOVE: begin
				if (list_count > 0 && c.value <= list_vals[0] &&
						c.value >= list_vals[list_count-1]) begin
					idx = 0;
					while (idx < list_count && list_vals[idx] > c.value)
						idx++;
					if (idx < list_count && list_vals[idx] == c.value) begin
						remove_at(idx);
						ok = 1'b1;
					end
				end
			end
			OP_DROP_NEG, OP_DROP_EVEN: begin
				idx = 0;
				while (idx < list_count) begin
					drop = (c.operation == OP_DROP_EVEN) ? !list_vals[idx][0] :
						list_vals[idx][DATA_W-1];
					if (drop) begin
						remove_at(idx);
						ok = 1'b1;
					end else begin
						idx++;
					end
				end
			end
			OP_READ: begin
				if (c.position >= 1 && c.position <= list_count) begin
					elem = list_vals[c.position - 1];
					ok   = 1'b1;
				end
			end
			OP_CLEAR: begin
				list_count = 0;
				ok         = 1'b1;
			end
			default: ;
		endcase

		r.ok       = ok;
		r.element  = elem;
		r.count    = COUNT_W'(list_count);
		r.is_empty = (list_count == 0);
		r.is_full  = (list_count == LIST_DEPTH);
		return r;
	endfunction

	task automatic check_field(string name, longint want, longint got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatch_cnt++;
		end
	endtask

	// ------------------------------------------------------------------
	// Monitor: check taken responses, then predict for taken commands
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		rsp_item_t want;

		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (expected_status.size() == 0) begin
					$error("response item with no command outstanding");
					mismatch_cnt++;
				end else begin
					want = expected_status.pop_front();
					check_field("ok", longint'(want.ok), longint'(rsp_ch.data.ok));
					check_field("element", longint'(want.element),
						longint'(rsp_ch.data.element));
					check_field("count", longint'(want.count), longint'(rsp_ch.data.count));
					check_field("is_empty", longint'(want.is_empty),
						longint'(rsp_ch.data.is_empty));
					check_field("is_full", longint'(want.is_full),
						longint'(rsp_ch.data.is_full));
				end
				n_done <= n_done + 1;
			end

			if (cmd_ch.valid && cmd_ch.ready) begin
				want = apply_to_list(cmd_ch.data);
				expected_status.push_back(want);
				n_taken <= n_taken + 1;
				op_tally[cmd_ch.data.operation]++;
				if (want.ok)
					ok_tally++;
				if (cmd_ch.data.operation == OP_INSERT && !want.ok)
					full_refusals++;
				if (list_count > peak_fill)
					peak_fill = list_count;
			end
		end
	end

	// ------------------------------------------------------------------
	// Driver: bursts with random gaps, drained pauses on request
	// ------------------------------------------------------------------
	int        burst_left;
	int        gap_left;
	list_req_t next_req;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_ch.valid <= 1'b0;
		end else if (!cmd_ch.valid || cmd_ch.ready) begin
			// The slot is free, or its item is taken at this edge.
			if (gap_left > 0) begin
				gap_left--;
				cmd_ch.valid <= 1'b0;
			end else if (cmd_backlog.size() == 0) begin
				cmd_ch.valid <= 1'b0;
			end else if (cmd_backlog[0].settle && (cmd_ch.valid || n_taken != n_done)) begin
				// Hold back until every response has come home.
				cmd_ch.valid <= 1'b0;
			end else begin
				next_req = cmd_backlog.pop_front();
				cmd_ch.data  <= next_req.cmd;
				cmd_ch.valid <= 1'b1;
				if (burst_left <= 1) begin
					// Now and then run a long burst with no gap at all.
					if ($urandom_range(7, 0) == 0) begin
						burst_left = 64;
						gap_left   = 0;
					end else begin
						burst_left = $urandom_range(24, 1);
						gap_left   = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(8, 1);
					end
				end else begin
					burst_left--;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Receiver: rotating stall patterns plus two long hold-offs
	// ------------------------------------------------------------------
	rx_mode_t    rx_mode;
	int          mode_left;
	int unsigned rx_phase;
	int          hold_left;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			// Start a long hold-off once the run is well under way.
			if (hold_left == 0 && holds_done < 2 &&
					n_taken >= ((holds_done == 0) ? 300 : 1000)) begin
				hold_left = LONG_HOLD;
				holds_done++;
			end
			if (mode_left == 0) begin
				rx_mode   = rx_mode_t'($urandom_range(3, 0));
				mode_left = $urandom_range(150, 40);
			end else begin
				mode_left--;
			end
			rx_phase++;

			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				case (rx_mode)
					RX_OPEN:   rsp_ch.ready <= 1'b1;
					RX_COIN:   rsp_ch.ready <= 1'($urandom_range(1, 0));
					RX_SPARSE: rsp_ch.ready <= ($urandom_range(3, 0) == 0);
					default:   rsp_ch.ready <= rx_phase[2];
				endcase
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	task automatic queue_cmd(logic [OP_W-1:0] op, entry_t val, logic [POS_W-1:0] pos,
			bit settle = 1'b0);
		list_req_t req;

		req.cmd.operation = op;
		req.cmd.value     = val;
		req.cmd.position  = pos;
		req.settle        = settle;
		cmd_backlog.push_back(req);
	endtask

	// Mostly a narrow band so removes find their value; some extremes.
	function automatic entry_t pick_value();
		int unsigned r;

		r = $urandom_range(99, 0);
		if (r < 60)
			return entry_t'($signed($urandom_range(24, 0)) - 12);
		if (r < 75) begin
			case ($urandom_range(5, 0))
				0: return 32'h7fff_ffff;
				1: return 32'h8000_0000;
				2: return 32'h7fff_fffe;
				3: return 32'h8000_0001;
				4: return '0;
				default: return '1;
			endcase
		end
		return entry_t'($urandom());
	endfunction

	initial begin
		int          episode;
		int          n_fill;
		int          n_mix;
		int unsigned r;

		arst_n       = 1'b0;
		cmd_ch.valid = 1'b0;
		cmd_ch.data  = '0;
		rsp_ch.ready = 1'b0;
		list_count   = 0;
		n_taken      = 0;
		n_done       = 0;
		mismatch_cnt = 0;
		burst_left   = 0;
		gap_left     = 0;
		mode_left    = 0;
		rx_phase     = 0;
		hold_left    = 0;
		holds_done   = 0;
		ok_tally     = 0;
		peak_fill    = 0;
		full_refusals = 0;
		foreach (op_tally[i])
			op_tally[i] = 0;

		// Directed: read, remove and both sweeps on an empty list must fail.
		queue_cmd(OP_READ, '0, 6'd1);
		queue_cmd(OP_REMOVE, '0, '0);
		queue_cmd(OP_DROP_NEG, '0, '0);
		queue_cmd(OP_DROP_EVEN, '0, '0);
		// Remove outside the span and remove of an absent value.
		queue_cmd(OP_INSERT, 32'sd100, '0);
		queue_cmd(OP_INSERT, -32'sd100, '0);
		queue_cmd(OP_REMOVE, 32'sd200, '0);
		queue_cmd(OP_REMOVE, -32'sd200, '0);
		queue_cmd(OP_REMOVE, 32'sd7, '0);
		// Value extremes and a duplicate.
		queue_cmd(OP_INSERT, 32'h7fff_ffff, '0);
		queue_cmd(OP_INSERT, 32'h8000_0000, '0);
		queue_cmd(OP_INSERT, 32'sd5, '0);
		queue_cmd(OP_INSERT, 32'sd5, '0);
		queue_cmd(OP_INSERT, -32'sd1, '0);
		// Reads at position zero, first, last, one past and far past.
		queue_cmd(OP_READ, '0, 6'd0);
		queue_cmd(OP_READ, '0, 6'd1);
		queue_cmd(OP_READ, '0, 6'd7);
		queue_cmd(OP_READ, '0, 6'd8);
		queue_cmd(OP_READ, '0, 6'd63);
		queue_cmd(OP_UNUSED_6, 32'sd5, 6'd1);
		queue_cmd(OP_UNUSED_7, 32'sd5, 6'd1);
		queue_cmd(OP_REMOVE, 32'sd5, '0);
		// Sweeps: the second one finds nothing left to drop.
		queue_cmd(OP_DROP_NEG, '0, '0);
		queue_cmd(OP_DROP_NEG, '0, '0);
		queue_cmd(OP_DROP_EVEN, '0, '0);
		queue_cmd(OP_CLEAR, '0, '0);

		// Random: mostly fill-then-work episodes, some pure noise.
		episode = 0;
		while (cmd_backlog.size() < RANDOM_ITEMS + 26) begin
			if ($urandom_range(9, 0) < 8) begin
				if ($urandom_range(4, 0) != 0)
					queue_cmd(OP_CLEAR, pick_value(), POS_W'($urandom_range(63, 0)),
						(episode % 12) == 5);
				n_fill = ($urandom_range(3, 0) == 0) ?
					$urandom_range(LIST_DEPTH + 3, LIST_DEPTH - 2) :
					$urandom_range(LIST_DEPTH / 2, 1);
				for (int i = 0; i < n_fill; i++)
					queue_cmd(OP_INSERT, pick_value(), POS_W'($urandom_range(63, 0)));
				n_mix = $urandom_range(30, 4);
				for (int i = 0; i < n_mix; i++) begin
					r = $urandom_range(99, 0);
					if (r < 35)
						queue_cmd(OP_READ, pick_value(),
							POS_W'($urandom_range(n_fill + 1, 0)));
					else if (r < 60)
						queue_cmd(OP_REMOVE, pick_value(), POS_W'($urandom_range(63, 0)));
					else if (r < 75)
						queue_cmd(OP_INSERT, pick_value(), POS_W'($urandom_range(63, 0)));
					else if (r < 82)
						queue_cmd(OP_DROP_NEG, pick_value(), POS_W'($urandom_range(63, 0)));
					else if (r < 89)
						queue_cmd(OP_DROP_EVEN, pick_value(), POS_W'($urandom_range(63, 0)));
					else
						queue_cmd(OP_W'($urandom_range(7, 0)), entry_t'($urandom()),
							POS_W'($urandom_range(63, 0)));
				end
			end else begin
				n_mix = $urandom_range(30, 10);
				for (int i = 0; i < n_mix; i++)
					queue_cmd(OP_W'($urandom_range(7, 0)), entry_t'($urandom()),
						POS_W'($urandom_range(63, 0)), (i == 0) && ((episode % 12) == 11));
			end
			episode++;
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Drain: everything sent, every response back, then let a full
		// sweep's worth of cycles pass to catch stray responses.
		while (cmd_backlog.size() != 0 || cmd_ch.valid || n_done != n_taken)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (expected_status.size() != 0) begin
			$error("%0d responses never arrived", expected_status.size());
			mismatch_cnt++;
		end

		$write("Checked %0d responses (%0d ok): %0d insert, %0d remove, %0d drop-neg, ",
			n_done, ok_tally, op_tally[OP_INSERT], op_tally[OP_REMOVE],
			op_tally[OP_DROP_NEG]);
		$display("%0d drop-even, %0d read, %0d clear, %0d unused codes.",
			op_tally[OP_DROP_EVEN], op_tally[OP_READ], op_tally[OP_CLEAR],
			op_tally[OP_UNUSED_6] + op_tally[OP_UNUSED_7]);
		$write("Peak fill %0d of %0d, %0d inserts refused when full, ",
			peak_fill, LIST_DEPTH, full_refusals);
		$display("%0d long receiver hold-offs.", holds_done);
		if (mismatch_cnt == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// Guard against a hung handshake.
	initial begin
		#2_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+design
design/sdl_pkg.sv
design/sdl_stream_if.sv
design/sdl_cell.sv
design/sorted_descending_list_top.sv
design/sdl_checker.sv
tb/sorted_descending_list_top_tb.sv
